>>> hdl/tbs_pkg.sv
// Shared types, constants and helper functions for the binding site scanner.
// No dependencies; the cell, the result queue, the top level and the testbench import this package.
package tbs_pkg;

  localparam int unsigned MAX_REPEATS_DEF = 64;
  localparam int unsigned SCORE_BITS_DEF  = 16;

  localparam int unsigned ACC_W     = 22;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam int unsigned POS_W     = 32;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 22;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned VAL_W     = 16;

  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_UC_C = 8'h43;
  localparam logic [7:0] CHAR_LC_C = 8'h63;
  localparam logic [7:0] CHAR_UC_G = 8'h47;
  localparam logic [7:0] CHAR_LC_G = 8'h67;
  localparam logic [7:0] CHAR_UC_T = 8'h54;
  localparam logic [7:0] CHAR_LC_T = 8'h74;

  typedef enum logic [1:0] {
    COL_A = 2'd0,
    COL_C = 2'd1,
    COL_G = 2'd2,
    COL_T = 2'd3
  } tbs_col_e;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CHAR    = 2'd1,
    CMD_NEW_SEQ = 2'd2
  } tbs_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_SCORE_CUTOFF   = 1'b1
  } tbs_cfg_e;

  typedef struct packed {
    logic     ok;
    tbs_col_e col;
  } tbs_base_t;

  typedef struct packed {
    logic     shift;
    logic     clear;
    logic     col_ok;
    tbs_col_e col;
  } tbs_step_t;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] row;
    tbs_col_e         base;
    logic [VAL_W-1:0] value;
  } tbs_load_t;

  function automatic tbs_base_t base_decode(input logic [7:0] ch);
    tbs_base_t res;
    res.ok  = 1'b1;
    res.col = COL_A;
    unique case (ch)
      CHAR_UC_A, CHAR_LC_A: res.col = COL_A;
      CHAR_UC_C, CHAR_LC_C: res.col = COL_C;
      CHAR_UC_G, CHAR_LC_G: res.col = COL_G;
      CHAR_UC_T, CHAR_LC_T: res.col = COL_T;
      default:              res.ok  = 1'b0;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/tbs_req_if.sv
// Request channel of the binding site scanner: valid/ready plus the request fields.
// Depends on nothing.
interface tbs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  base_char;
  logic [5:0]  score_row;
  logic [1:0]  score_base;
  logic [15:0] score_value;

  modport source (output valid, cmd, base_char, score_row, score_base, score_value,
                  input ready);
  modport sink (input valid, cmd, base_char, score_row, score_base, score_value,
                output ready);
endinterface

>>> hdl/tbs_rsp_if.sv
// Result channel of the binding site scanner: valid/ready plus the site position.
// Depends on nothing.
interface tbs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] site_position;

  modport source (output valid, site_position, input ready);
  modport sink (input valid, site_position, output ready);
endinterface

>>> hdl/tbs_cell.sv
// One stage of the partial-sum chain: a score row, a window sum and a T flag.
// Depends on tbs_pkg.
module tbs_cell import tbs_pkg::*; #(
  parameter int unsigned Idx       = 0,
  parameter int unsigned ScoreBits = SCORE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbs_step_t        step_i,
  input  tbs_load_t        load_i,
  input  logic             tap_i,
  input  logic [ACC_W-1:0] cutoff_i,
  input  logic [ACC_W-1:0] sum_i,
  input  logic             flag_i,
  output logic [ACC_W-1:0] sum_o,
  output logic             flag_o,
  output logic             hit_o
);

  localparam int unsigned SumW = ((ACC_W > ScoreBits) ? ACC_W : ScoreBits) + 1;

  logic [ScoreBits-1:0] score_q [4];
  logic [ScoreBits-1:0] load_val;
  logic [ScoreBits-1:0] score_sel;
  logic [ACC_W-1:0]     sum_q, sum_d;
  logic                 flag_q, flag_d;
  logic [SumW-1:0]      wide_sum;
  logic [47:0]          val_ext;

  assign val_ext  = {32'd0, load_i.value};
  assign load_val = val_ext[ScoreBits-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i.we && (32'(load_i.row) == Idx)) begin
      score_q[load_i.base] <= load_val;
    end
  end

  assign score_sel = step_i.col_ok ? score_q[step_i.col] : '0;
  assign wide_sum  = SumW'(sum_q) + SumW'(score_sel);
  assign sum_o     = (wide_sum > SumW'(ACC_MAX)) ? ACC_MAX : wide_sum[ACC_W-1:0];
  assign flag_o    = flag_q;
  assign hit_o     = tap_i && flag_q && (sum_o <= cutoff_i);

  always_comb begin
    sum_d  = sum_q;
    flag_d = flag_q;
    priority if (step_i.clear) begin
      sum_d  = '0;
      flag_d = 1'b0;
    end else if (step_i.shift) begin
      sum_d  = sum_i;
      flag_d = flag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      flag_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      flag_q <= flag_d;
    end
  end

endmodule

>>> hdl/tbs_out_queue.sv
// Two-entry result queue that decouples the scan chain from the result channel.
// Depends on tbs_pkg and tbs_rsp_if.
module tbs_out_queue import tbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [POS_W-1:0] data_i,
  output logic             space_o,
  tbs_rsp_if.source        rsp
);

  logic [POS_W-1:0] data_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             pop;

  assign space_o           = (count_q != 2'd2);
  assign rsp.valid         = (count_q != 2'd0);
  assign rsp.site_position = data_q[rd_ptr_q];
  assign pop               = rsp.valid && rsp.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

>>> hdl/tal_binding_site_scan.sv
// Binding site scanner top level: a chain of partial-sum cells and a result queue.
// Depends on tbs_pkg, tbs_req_if, tbs_rsp_if, tbs_cell and tbs_out_queue.
//
// The scanner takes one request every clock cycle: score loads, sequence characters and
// new-sequence marks all complete in the cycle they are accepted, because each cell of the
// chain adds its row score and hands its window sum to the next cell in that cycle. A site
// found by a character enters a two-entry result queue and is offered on the result channel
// in the next cycle if the queue was empty; requests stall only while both queue entries wait to be taken.
// Configuration writes should be made while no request is in flight.
module tal_binding_site_scan import tbs_pkg::*; #(
  parameter int unsigned MaxRepeats = MAX_REPEATS_DEF,
  parameter int unsigned ScoreBits  = SCORE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  tbs_req_if.sink              req,
  tbs_rsp_if.source            rsp
);

  localparam int unsigned LenW = $clog2(MaxRepeats + 1);

  logic [LEN_W-1:0]  pattern_length_q;
  logic [ACC_W-1:0]  score_cutoff_q;
  logic [POS_W-1:0]  char_count_q, char_count_d;
  logic [LenW-1:0]   len_eff;
  logic              accept;
  logic              space;
  tbs_base_t         base;
  tbs_step_t         step;
  tbs_load_t         load;
  logic [ACC_W-1:0]  cell_sum [MaxRepeats];
  logic              cell_flag [MaxRepeats];
  logic [MaxRepeats-1:0] cell_hit;
  logic              push;
  logic [POS_W-1:0]  push_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= LEN_W'(1);
      score_cutoff_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (tbs_cfg_e'(cfg_idx_i))
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_SCORE_CUTOFF:   score_cutoff_q   <= cfg_wdata_i[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pattern_length_q == '0) begin
      len_eff = LenW'(1);
    end else if (32'(pattern_length_q) > MaxRepeats) begin
      len_eff = LenW'(MaxRepeats);
    end else begin
      len_eff = LenW'(pattern_length_q);
    end
  end

  assign req.ready = space;
  assign accept    = req.valid && space;
  assign base      = base_decode(req.base_char);

  assign step.shift  = accept && (req.cmd == CMD_CHAR);
  assign step.clear  = accept && (req.cmd == CMD_NEW_SEQ);
  assign step.col_ok = base.ok;
  assign step.col    = base.col;

  assign load.we    = accept && (req.cmd == CMD_LOAD);
  assign load.row   = req.score_row;
  assign load.base  = tbs_col_e'(req.score_base);
  assign load.value = req.score_value;

  for (genvar k = 0; k < MaxRepeats; k++) begin : g_cell
    tbs_cell #(
      .Idx       (k),
      .ScoreBits (ScoreBits)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .load_i   (load),
      .tap_i    (len_eff == LenW'(k + 1)),
      .cutoff_i (score_cutoff_q),
      .sum_i    ((k == 0) ? '0 : cell_sum[(k == 0) ? 0 : k - 1]),
      .flag_i   ((k == 0) ? (base.ok && (base.col == COL_T))
                          : cell_flag[(k == 0) ? 0 : k - 1]),
      .sum_o    (cell_sum[k]),
      .flag_o   (cell_flag[k]),
      .hit_o    (cell_hit[k])
    );
  end

  assign push     = step.shift && (|cell_hit);
  assign push_pos = char_count_q - POS_W'(len_eff) + POS_W'(1);

  always_comb begin
    char_count_d = char_count_q;
    priority if (step.clear) begin
      char_count_d = '0;
    end else if (step.shift) begin
      char_count_d = char_count_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
    end else begin
      char_count_q <= char_count_d;
    end
  end

  tbs_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_pos),
    .space_o (space),
    .rsp     (rsp)
  );

endmodule

>>> verif/tal_binding_site_scan_tb.sv
// Self-checking testbench for tal_binding_site_scan: directed and random request streams,
// with sites predicted by a scoring chain kept here and checked in order.
// Depends on tbs_pkg, tbs_req_if, tbs_rsp_if and the scanner RTL.
module tal_binding_site_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned PRINT_CAP   = 100;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 190;

  localparam int unsigned PHASE_LEN [PHASES] = '{3, 64, 0, 127, 8, 17, 1};
  localparam int unsigned PHASE_CUT [PHASES] =
    '{4194303, 4194303, 2000, 131072, 16000, 40000, 0};
  // Phases with a clear bit carry on the sequence left by the phase before.
  localparam logic [PHASES-1:0] PHASE_RESTART = 7'b1100111;

  typedef enum logic [1:0] {
    GAP_SENDER_LIGHT,
    GAP_SENDER_HEAVY,
    GAP_NONE
  } gap_mode_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       base_char;
    logic [ROW_W-1:0] row;
    logic [1:0]       base;
    logic [VAL_W-1:0] value;
  } scan_req_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  tbs_req_if req_if ();
  tbs_rsp_if rsp_if ();

  tal_binding_site_scan DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  logic [VAL_W-1:0] score_tab [MAX_REPEATS_DEF*4];
  logic [ACC_W-1:0] chain_sum [MAX_REPEATS_DEF];
  logic             chain_t   [MAX_REPEATS_DEF];
  logic [POS_W-1:0] char_idx;
  logic [LEN_W-1:0] len_reg;
  logic [ACC_W-1:0] cutoff_reg;

  scan_req_t        scan_req_q  [$];
  logic [POS_W-1:0] due_sites_q [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_left;
  bit          hold_done;
  bit          long_hold_req;
  gap_mode_e   gap_mode;

  function automatic int base_col(logic [7:0] ch);
    case (ch)
      CHAR_UC_A, CHAR_LC_A: return int'(COL_A);
      CHAR_UC_C, CHAR_LC_C: return int'(COL_C);
      CHAR_UC_G, CHAR_LC_G: return int'(COL_G);
      CHAR_UC_T, CHAR_LC_T: return int'(COL_T);
      default:              return -1;
    endcase
  endfunction

  function automatic logic [ACC_W-1:0] add_score(logic [ACC_W-1:0] acc, int unsigned row,
                                                  int col);
    logic [ACC_W:0] s;
    if (col < 0) return acc;
    s = acc + score_tab[row*4 + col];
    return (s > ACC_MAX) ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  function automatic void clear_chain();
    for (int k = 0; k < MAX_REPEATS_DEF; k++) begin
      chain_sum[k] = '0;
      chain_t[k]   = 1'b0;
    end
    char_idx = '0;
  endfunction

  task automatic scan_step(scan_req_t r);
    int unsigned      eff_len;
    int               col;
    logic [ACC_W-1:0] total;
    case (r.cmd)
      CMD_LOAD: score_tab[{r.row, r.base}] = r.value;
      CMD_NEW_SEQ: clear_chain();
      CMD_CHAR: begin
        eff_len = (len_reg == 0) ? 1 :
                  (len_reg > MAX_REPEATS_DEF) ? MAX_REPEATS_DEF : len_reg;
        col = base_col(r.base_char);
        total = add_score(chain_sum[eff_len-1], eff_len-1, col);
        if (chain_t[eff_len-1] && total <= cutoff_reg) begin
          due_sites_q.push_back(char_idx - (eff_len - 1));
        end
        for (int j = MAX_REPEATS_DEF - 1; j >= 1; j--) begin
          chain_sum[j] = add_score(chain_sum[j-1], j - 1, col);
          chain_t[j]   = chain_t[j-1];
        end
        chain_sum[0] = '0;
        chain_t[0]   = (col == int'(COL_T));
        char_idx++;
      end
      default: ;
    endcase
  endtask

  function automatic scan_req_t make_req(logic [1:0] cmd, logic [7:0] ch,
                                         logic [ROW_W-1:0] row, logic [1:0] base,
                                         logic [VAL_W-1:0] value);
    scan_req_t r;
    r.cmd       = cmd;
    r.base_char = ch;
    r.row       = row;
    r.base      = base;
    r.value     = value;
    return r;
  endfunction

  // Mostly characters with plenty of T, so that windows preceded by T are common.
  function automatic scan_req_t rand_request();
    scan_req_t   r;
    int unsigned k;
    r.base_char = 8'($urandom);
    r.row       = ROW_W'($urandom);
    r.base      = 2'($urandom);
    r.value     = VAL_W'($urandom);
    k = $urandom_range(0, 99);
    if (k < 6) begin
      r.cmd = CMD_LOAD;
      k = $urandom_range(0, 9);
      if (k == 0) r.value = '0;
      else if (k == 1) r.value = '1;
      else if (k < 9) r.value = VAL_W'($urandom_range(0, 4095));
    end else if (k < 7) begin
      r.cmd = CMD_NEW_SEQ;
    end else if (k < 9) begin
      r.cmd = CMD_UNUSED;
    end else begin
      r.cmd = CMD_CHAR;
      k = $urandom_range(0, 99);
      if (k < 32) r.base_char = $urandom_range(0, 1) ? CHAR_UC_T : CHAR_LC_T;
      else if (k < 52) r.base_char = $urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A;
      else if (k < 72) r.base_char = $urandom_range(0, 1) ? CHAR_UC_C : CHAR_LC_C;
      else if (k < 90) r.base_char = $urandom_range(0, 1) ? CHAR_UC_G : CHAR_LC_G;
    end
    return r;
  endfunction

  function automatic int unsigned gap_pct(bit receiver_side);
    case (gap_mode)
      GAP_SENDER_LIGHT: return receiver_side ? 75 : 13;
      GAP_SENDER_HEAVY: return receiver_side ? 13 : 75;
      default:          return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("%0t ERROR %s", $realtime, what);
    mismatches++;
  endtask

  task automatic write_reg(tbs_cfg_e idx, logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PATTERN_LENGTH) len_reg = data[LEN_W-1:0];
    else cutoff_reg = data;
  endtask

  task automatic wait_idle();
    while (scan_req_q.size() != 0 || due_sites_q.size() != 0 || req_if.valid) begin
      @(negedge clk_i);
    end
    repeat (5) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        scan_step(scan_req_q.pop_front());
      end
      if (!req_if.valid || req_if.ready) begin
        if (scan_req_q.size() != 0 && $urandom_range(0, 99) >= gap_pct(1'b0)) begin
          req_if.valid       <= 1'b1;
          req_if.cmd         <= scan_req_q[0].cmd;
          req_if.base_char   <= scan_req_q[0].base_char;
          req_if.score_row   <= scan_req_q[0].row;
          req_if.score_base  <= scan_req_q[0].base;
          req_if.score_value <= scan_req_q[0].value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (due_sites_q.size() == 0) begin
          report_mismatch($sformatf("unexpected site at %0d", rsp_if.site_position));
        end else begin
          if (rsp_if.site_position !== due_sites_q[0]) begin
            report_mismatch($sformatf("site_position %0d, expected %0d",
                                      rsp_if.site_position, due_sites_q[0]));
          end
          void'(due_sites_q.pop_front());
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= gap_pct(1'b1));
    end
  end

  initial begin
    string            opening;
    logic [VAL_W-1:0] v;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_PATTERN_LENGTH;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.cmd         = CMD_CHAR;
    req_if.base_char   = '0;
    req_if.score_row   = '0;
    req_if.score_base  = '0;
    req_if.score_value = '0;
    rsp_if.ready       = 1'b0;
    len_reg            = LEN_W'(1);
    cutoff_reg         = '0;
    clear_chain();
    gap_mode      = GAP_SENDER_LIGHT;
    long_hold_req = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every score entry is loaded before the first character is sent.
    for (int r = 0; r < MAX_REPEATS_DEF; r++) begin
      for (int b = 0; b < 4; b++) begin
        if (r == 0) begin
          case (b)
            int'(COL_C): v = '1;
            int'(COL_G): v = 16'h0800;
            default:     v = '0;
          endcase
        end else begin
          v = ($urandom_range(0, 15) == 0) ? '0 : VAL_W'($urandom_range(0, 4095));
        end
        scan_req_q.push_back(make_req(CMD_LOAD, 8'h00, ROW_W'(r), 2'(b), v));
      end
    end

    // Reset settings: single-base windows, only a zero score is accepted.
    opening = "TAtaTCTNTgGc";
    for (int i = 0; i < opening.len(); i++) begin
      scan_req_q.push_back(make_req(CMD_CHAR, opening[i], '0, '0, '0));
    end
    scan_req_q.push_back(make_req(CMD_CHAR, 8'h00, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_CHAR, 8'hFF, '1, '1, '1));
    scan_req_q.push_back(make_req(CMD_CHAR, CHAR_UC_T, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_UNUSED, 8'hFF, '1, '1, '1));
    scan_req_q.push_back(make_req(CMD_CHAR, CHAR_UC_T, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_NEW_SEQ, CHAR_UC_T, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_CHAR, CHAR_UC_A, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_CHAR, CHAR_UC_T, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_LOAD, 8'h00, '0, COL_A, '1));
    scan_req_q.push_back(make_req(CMD_CHAR, CHAR_LC_A, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_LOAD, 8'h00, '0, COL_A, '0));
    scan_req_q.push_back(make_req(CMD_LOAD, 8'h00, '1, COL_T, '1));
    scan_req_q.push_back(make_req(CMD_CHAR, CHAR_LC_T, '0, '0, '0));
    scan_req_q.push_back(make_req(CMD_CHAR, CHAR_LC_A, '0, '0, '0));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_PATTERN_LENGTH, CFG_DAT_W'(PHASE_LEN[p]));
      write_reg(CFG_SCORE_CUTOFF, CFG_DAT_W'(PHASE_CUT[p]));
      if (p < 3) gap_mode <= GAP_SENDER_LIGHT;
      else if (p < 5) gap_mode <= GAP_SENDER_HEAVY;
      else gap_mode <= GAP_NONE;
      if (p == 0) long_hold_req <= 1'b1;
      @(negedge clk_i);
      if (PHASE_RESTART[p]) begin
        scan_req_q.push_back(make_req(CMD_NEW_SEQ, 8'h00, '0, '0, '0));
      end
      repeat (PHASE_ITEMS) scan_req_q.push_back(rand_request());
    end

    wait_idle();
    repeat (5) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/tbs_pkg.sv
hdl/tbs_req_if.sv
hdl/tbs_rsp_if.sv
hdl/tbs_cell.sv
hdl/tbs_out_queue.sv
hdl/tal_binding_site_scan.sv
verif/tal_binding_site_scan_tb.sv
